// ===== rtl/tcia_pkg.sv =====
// Shared types, codes and constants for the typed checked integer ALU.
package tcia_pkg;

   localparam int DataWidth = 32;
   localparam int QuotWidth = 32;
   localparam int OpWidth = 3;
   localparam int TagWidth = 2;
   localparam int StatusWidth = 2;

   localparam logic signed [63:0] I8_HI = 64'sd127;
   localparam logic signed [63:0] I8_LO = -64'sd128;
   localparam logic signed [63:0] I16_HI = 64'sd32767;
   localparam logic signed [63:0] I16_LO = -64'sd32768;
   localparam logic signed [63:0] I32_HI = 64'sd2147483647;
   localparam logic signed [63:0] I32_LO = -64'sd2147483648;

   typedef enum logic [OpWidth-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_REM = 3'd4
   } op_type;

   typedef enum logic [TagWidth-1:0] {
      TAG_I8 = 2'd0,
      TAG_I16 = 2'd1,
      TAG_I32 = 2'd2
   } tag_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK = 2'd0,
      ST_OVER = 2'd1,
      ST_UNDER = 2'd2,
      ST_DIVZ = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_DIV = 2'd1,
      KIND_REM = 2'd2
   } kind_type;

   // one item traveling through the divider cells
   typedef struct packed {
      logic valid;
      kind_type kind;
      tag_type tag;
      logic [StatusWidth-1:0] status;
      logic signed [63:0] direct;
      logic neg_q;
      logic neg_r;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] quo;
      logic [DataWidth-1:0] den;
   } cell_type;

   function automatic tag_type tag_norm(input logic [TagWidth-1:0] t);
      tag_type r;
      r = (t == 2'd3) ? TAG_I32 : tag_type'(t);
      return r;
   endfunction

   function automatic logic [StatusWidth-1:0] range_check(input logic signed [63:0] v,
                                                          input tag_type t);
      logic signed [63:0] mx;
      logic signed [63:0] mn;
      mx = (t == TAG_I8) ? I8_HI : (t == TAG_I16) ? I16_HI : I32_HI;
      mn = (t == TAG_I8) ? I8_LO : (t == TAG_I16) ? I16_LO : I32_LO;
      if (v > mx) return ST_OVER;
      if (v < mn) return ST_UNDER;
      return ST_OK;
   endfunction

   function automatic logic [DataWidth-1:0] wrap_out(input logic signed [63:0] v,
                                                     input tag_type t);
      logic [DataWidth-1:0] r;
      unique case (t)
         TAG_I8: r = {{24{v[7]}}, v[7:0]};
         TAG_I16: r = {{16{v[15]}}, v[15:0]};
         default: r = v[31:0];
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/tcia_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface tcia_req_if import tcia_pkg::*; ();
   logic valid;
   logic ready;
   logic [OpWidth-1:0] req_type;
   logic [TagWidth-1:0] type_a;
   logic signed [DataWidth-1:0] value_a;
   logic [TagWidth-1:0] type_b;
   logic signed [DataWidth-1:0] value_b;
   modport source (output valid, req_type, type_a, value_a, type_b, value_b, input ready);
   modport sink (input valid, req_type, type_a, value_a, type_b, value_b, output ready);
endinterface

interface tcia_rsp_if import tcia_pkg::*; ();
   logic valid;
   logic ready;
   logic [TagWidth-1:0] result_type;
   logic signed [DataWidth-1:0] result_value;
   logic [StatusWidth-1:0] status;
   modport source (output valid, result_type, result_value, status, input ready);
   modport sink (input valid, result_type, result_value, status, output ready);
endinterface

// ===== rtl/typed_checked_int_alu.sv =====
// Top level: typed checked integer ALU with a pipelined divider chain.
//  channel | dir | payload
//  req     | in  | req_type, type_a, value_a, type_b, value_b
//  rsp     | out | result_type, result_value, status
// One request per cycle while the output is not stalled; one setup stage,
// 32 divider cells and one output register. Every op flows through the
// chain of division cells. Synchronous active-high reset empties the pipeline.
// A stalled result stalls the whole chain; the output register takes a new
// result the cycle it is drained.
module typed_checked_int_alu import tcia_pkg::*; (
   input logic clock,
   input logic reset,
   tcia_req_if.sink req,
   tcia_rsp_if.source rsp
);
   logic advance;
   cell_type chain [QuotWidth+1];
   logic [TagWidth-1:0] rt;
   logic [DataWidth-1:0] rv;
   logic [StatusWidth-1:0] rs;
   logic valid_ff;
   logic [TagWidth-1:0] type_ff;
   logic [DataWidth-1:0] value_ff;
   logic [StatusWidth-1:0] status_ff;

   assign advance = !valid_ff || rsp.ready;
   assign req.ready = advance;

   tcia_front u_front (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req.valid), .op(req.req_type),
      .type_a(req.type_a), .value_a(req.value_a),
      .type_b(req.type_b), .value_b(req.value_b),
      .out(chain[0])
   );

   for (genvar i = 0; i < QuotWidth; i++) begin : g_cell
      tcia_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .in(chain[i]), .out(chain[i+1])
      );
   end

   tcia_back u_back (
      .in(chain[QuotWidth]), .result_type(rt), .result_value(rv), .status(rs)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= chain[QuotWidth].valid;
         type_ff <= rt;
         value_ff <= rv;
         status_ff <= rs;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.result_type = type_ff;
   assign rsp.result_value = value_ff;
   assign rsp.status = status_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_value))
      else $error("result dropped under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("request blocked with empty output");
   a_divz: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == ST_DIVZ |-> rsp.result_value == '0)
      else $error("nonzero value on divide by zero");
endmodule

// ===== rtl/tcia_front.sv =====
// Operand check, widening, add/sub/multiply and divider setup stage.
module tcia_front import tcia_pkg::*; (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic in_valid,
   input logic [OpWidth-1:0] op,
   input logic [TagWidth-1:0] type_a,
   input logic signed [DataWidth-1:0] value_a,
   input logic [TagWidth-1:0] type_b,
   input logic signed [DataWidth-1:0] value_b,
   output cell_type out
);
   tag_type ta, tb, tr;
   logic [StatusWidth-1:0] sa, sb;
   logic signed [63:0] a64, b64;
   logic signed [63:0] prod;
   logic [DataWidth-1:0] mag_a, mag_b;
   cell_type out_in, out_ff;

   always_comb begin
      ta = tag_norm(type_a);
      tb = tag_norm(type_b);
      tr = (ta > tb) ? ta : tb;
      a64 = 64'(value_a);
      b64 = 64'(value_b);
      prod = value_a * value_b;
      sa = range_check(a64, ta);
      sb = range_check(b64, tb);
      mag_a = value_a[31] ? (~value_a + 32'd1) : value_a;
      mag_b = value_b[31] ? (~value_b + 32'd1) : value_b;
      out_in = '0;
      out_in.valid = in_valid;
      out_in.tag = tr;
      out_in.kind = KIND_DIRECT;
      out_in.den = mag_b;
      out_in.quo = mag_a;
      out_in.neg_q = value_a[31] ^ value_b[31];
      out_in.neg_r = value_a[31];
      if (sa != ST_OK) begin
         out_in.status = sa;
      end else if (sb != ST_OK) begin
         out_in.status = sb;
      end else begin
         case (op)
            OP_ADD: begin
               out_in.direct = a64 + b64;
               out_in.status = range_check(out_in.direct, tr);
            end
            OP_SUB: begin
               out_in.direct = a64 - b64;
               out_in.status = range_check(out_in.direct, tr);
            end
            OP_MUL: begin
               out_in.direct = prod;
               out_in.status = range_check(out_in.direct, tr);
            end
            OP_DIV, OP_REM: begin
               if (value_b == '0) begin
                  out_in.status = ST_DIVZ;
               end else begin
                  out_in.kind = (op == OP_DIV) ? KIND_DIV : KIND_REM;
               end
            end
            default: out_in.status = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff <= out_in;
      end
   end

   assign out = out_ff;
endmodule

// ===== rtl/tcia_cell.sv =====
// One restoring-division cell: retires one quotient bit per cycle while the chain advances.
module tcia_cell import tcia_pkg::*; (
   input logic clock,
   input logic reset,
   input logic advance,
   input cell_type in,
   output cell_type out
);
   cell_type out_in, out_ff;
   logic [DataWidth:0] trial;
   logic [DataWidth-1:0] shifted;

   always_comb begin
      out_in = in;
      shifted = {in.rem[DataWidth-2:0], in.quo[DataWidth-1]};
      trial = {in.rem, in.quo[DataWidth-1]} - {1'b0, in.den};
      if (!trial[DataWidth]) begin
         out_in.rem = trial[DataWidth-1:0];
         out_in.quo = {in.quo[DataWidth-2:0], 1'b1};
      end else begin
         out_in.rem = shifted;
         out_in.quo = {in.quo[DataWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff <= out_in;
      end
   end

   assign out = out_ff;
endmodule

// ===== rtl/tcia_back.sv =====
// Sign fix, range check and wrap of quotient and remainder; direct results keep their front-end status.
module tcia_back import tcia_pkg::*; (
   input cell_type in,
   output logic [TagWidth-1:0] result_type,
   output logic [DataWidth-1:0] result_value,
   output logic [StatusWidth-1:0] status
);
   logic signed [63:0] q64, r64, v;

   always_comb begin
      q64 = {32'd0, in.quo};
      r64 = {32'd0, in.rem};
      if (in.neg_q) q64 = -q64;
      if (in.neg_r) r64 = -r64;
      result_type = in.tag;
      case (in.kind)
         KIND_DIV: v = q64;
         KIND_REM: v = r64;
         default: v = in.direct;
      endcase
      if (in.kind == KIND_DIRECT) begin
         status = in.status;
         result_value = (in.status == ST_OK || in.status == ST_OVER ||
                         in.status == ST_UNDER) && in.direct != 64'sd0
                        ? wrap_out(v, in.tag) : '0;
      end else begin
         status = range_check(v, in.tag);
         result_value = wrap_out(v, in.tag);
      end
   end
endmodule
